FILE: rtl/assert_macros.svh
// Assertion helpers; expect clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/acr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package acr_pkg;

  localparam int ACR_CORDIC_STEPS = 16;
  localparam int ACR_SQRT_STEPS   = 31;
  localparam int ACR_DIV_STEPS    = 31;

  localparam int ACR_XW    = 34;  // cordic x/y, Q30
  localparam int ACR_ZW    = 33;  // cordic residual angle, Q30
  localparam int ACR_REMW  = 63;  // sqrt remainder
  localparam int ACR_ROOTW = 31;  // sqrt root / divisor
  localparam int ACR_DVW   = 62;  // divider remainder

  localparam logic signed [ACR_XW-1:0] ACR_GAIN = 34'sd652032875;
  localparam logic [19:0] ACR_DEG2RAD  = 20'd292818;
  localparam int ACR_FULL_TURN    = 23040;
  localparam int ACR_HALF_TURN    = 11520;
  localparam int ACR_QUARTER_TURN = 5760;
  localparam logic [15:0] ACR_ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic            zero;
    logic            flip;
    logic [2:0]      neg;
    logic [2:0][15:0] mag;
  } acr_side_t;

  function automatic logic [ACR_ZW-1:0] acr_atan(input int idx);
    case (idx)
      0:  return 33'd843314857;
      1:  return 33'd497837829;
      2:  return 33'd263043837;
      3:  return 33'd133525159;
      4:  return 33'd67021687;
      5:  return 33'd33543516;
      6:  return 33'd16775851;
      7:  return 33'd8388437;
      8:  return 33'd4194283;
      9:  return 33'd2097149;
      10: return 33'd1048576;
      11: return 33'd524288;
      12: return 33'd262144;
      13: return 33'd131072;
      14: return 33'd65536;
      15: return 33'd32768;
      16: return 33'd16384;
      17: return 33'd8192;
      18: return 33'd4096;
      19: return 33'd2048;
      20: return 33'd1024;
      21: return 33'd512;
      22: return 33'd256;
      23: return 33'd128;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/axis_angle_rotation_matrix_top.sv
// The first row of an item is offered once the item has passed the stage pipeline
//   and the row buffer is free; rows 1..3 follow on later cycles.
// The four rows leave the row buffer one per cycle while out_stall is low; the
//   cell chains take an item per cycle unless a full row buffer stalls them.
// Reset (rst_n low at a clock edge) clears stage valid bits and the row buffer flags.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module axis_angle_rotation_matrix_top #(
  parameter int CORDIC_STEPS = acr_pkg::ACR_CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_angle_deg,
  input  wire logic signed [15:0] in_axis_x,
  input  wire logic signed [15:0] in_axis_y,
  input  wire logic signed [15:0] in_axis_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_row_index,
  output logic signed [15:0]      out_col0,
  output logic signed [15:0]      out_col1,
  output logic signed [15:0]      out_col2,
  output logic signed [15:0]      out_col3,
  output logic                    out_last_row,
  output logic                    out_axis_zero
);

  localparam int XW   = acr_pkg::ACR_XW;
  localparam int ZW   = acr_pkg::ACR_ZW;
  localparam int SQ   = acr_pkg::ACR_SQRT_STEPS;
  localparam int DV   = acr_pkg::ACR_DIV_STEPS;
  localparam int MIDX = 1 + SQ + DV;          // side stage aligned with quotients
  localparam int DLY  = SQ + DV - CORDIC_STEPS;
  localparam int NST  = MIDX + 5;

  localparam logic signed [16:0] FULL17  = 17'(acr_pkg::ACR_FULL_TURN);
  localparam logic signed [16:0] HALF17  = 17'(acr_pkg::ACR_HALF_TURN);
  localparam logic signed [16:0] QUART17 = 17'(acr_pkg::ACR_QUARTER_TURN);
  localparam logic signed [XW:0] ONE35   = 35'sd1073741824;
  localparam logic signed [63:0] RND29   = 64'sd536870912;
  localparam logic signed [71:0] RND45   = 72'sd35184372088832;
  localparam int PIDX [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767)
      return 16'h7fff;
    else if (v < -26'sd32768)
      return 16'h8000;
    else
      return v[15:0];
  endfunction

  // ---------------- flow control ----------------
  logic [NST-1:0] v_r;
  logic adv, load, out_acc, last;
  logic       ov_r, zb_r;
  logic [1:0] row_r;
  logic [15:0] eb_r [9];

  assign out_acc  = ov_r & ~out_stall;
  assign last     = row_r == 2'd3;
  assign load     = v_r[NST-1] & (~ov_r | (out_acc & last));
  assign adv      = ~v_r[NST-1] | load;
  assign in_stall = ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // ---------------- front: angle reduce, squares ----------------
  logic signed [16:0] a0, a1, a2, m17, mf;
  logic               flip0;
  logic signed [35:0] zr_full;
  acr_pkg::acr_side_t sd_in;
  acr_pkg::acr_side_t sd_r [0:MIDX];
  logic signed [ZW-1:0] zr0_r, zr1_r;
  logic [31:0] sq_r [3];
  logic [31:0] l2_r;

  always_comb begin
    a0 = {in_angle_deg[15], in_angle_deg};
    a1 = a0[16] ? a0 + FULL17 : ((a0 >= FULL17) ? a0 - FULL17 : a0);
    a2 = a1[16] ? a1 + FULL17 : a1;
    m17 = (a2 >= HALF17) ? a2 - FULL17 : a2;
    flip0 = 1'b0;
    mf = m17;
    if (m17 > QUART17) begin
      mf = HALF17 - m17;
      flip0 = 1'b1;
    end else if (m17 < -QUART17) begin
      mf = -HALF17 - m17;
      flip0 = 1'b1;
    end
    zr_full = mf * $signed({1'b0, acr_pkg::ACR_DEG2RAD});
    sd_in.zero   = (in_axis_x == 16'sd0) && (in_axis_y == 16'sd0) && (in_axis_z == 16'sd0);
    sd_in.flip   = flip0;
    sd_in.neg    = {in_axis_z[15], in_axis_y[15], in_axis_x[15]};
    sd_in.mag[0] = abs16(in_axis_x);
    sd_in.mag[1] = abs16(in_axis_y);
    sd_in.mag[2] = abs16(in_axis_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zr0_r    <= zr_full[ZW-1:0];
      sq_r[0]  <= sd_in.mag[0] * sd_in.mag[0];
      sq_r[1]  <= sd_in.mag[1] * sd_in.mag[1];
      sq_r[2]  <= sd_in.mag[2] * sd_in.mag[2];
      l2_r     <= sq_r[0] + sq_r[1] + sq_r[2];
      zr1_r    <= zr0_r;
      sd_r[0]  <= sd_in;
      for (int k = 1; k <= MIDX; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // ---------------- CORDIC chain ----------------
  logic signed [XW-1:0] cx [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
  logic signed [XW-1:0] xd_r [1:DLY];
  logic signed [XW-1:0] yd_r [1:DLY];

  assign cx[0] = acr_pkg::ACR_GAIN;
  assign cy[0] = '0;
  assign cz[0] = zr1_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    acr_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk), .en (adv),
      .x_i (cx[g]), .y_i (cy[g]), .z_i (cz[g]),
      .x_o (cx[g+1]), .y_o (cy[g+1]), .z_o (cz[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xd_r[1] <= cx[CORDIC_STEPS];
      yd_r[1] <= cy[CORDIC_STEPS];
      for (int k = 2; k <= DLY; k++) begin
        xd_r[k] <= xd_r[k-1];
        yd_r[k] <= yd_r[k-1];
      end
    end
  end

  // ---------------- square root chain ----------------
  logic [acr_pkg::ACR_REMW-1:0]  sr_rem  [0:SQ];
  logic [acr_pkg::ACR_ROOTW-1:0] sr_root [0:SQ];

  assign sr_rem[0]  = {1'b0, l2_r, 30'b0};
  assign sr_root[0] = '0;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    acr_sqrt_cell #(.BIT(SQ - 1 - g)) u_cell (
      .clk (clk), .en (adv),
      .rem_i (sr_rem[g]), .root_i (sr_root[g]),
      .rem_o (sr_rem[g+1]), .root_o (sr_root[g+1])
    );
  end

  // ---------------- divider chains, one lane per axis ----------------
  logic [acr_pkg::ACR_DVW-1:0]   dv_rem [3][0:DV];
  logic [acr_pkg::ACR_ROOTW-1:0] dv_den [3][0:DV];
  logic [acr_pkg::ACR_ROOTW-1:0] dv_q   [3][0:DV];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    // mag * 2^45 + len / 2, rounds the quotient half up
    assign dv_rem[l][0] = {1'b0, sd_r[SQ+1].mag[l], 45'b0}
                        + {32'b0, sr_root[SQ][acr_pkg::ACR_ROOTW-1:1]};
    assign dv_den[l][0] = sr_root[SQ];
    assign dv_q[l][0]   = '0;
    for (genvar g = 0; g < DV; g++) begin : g_div
      acr_div_cell #(.BIT(DV - 1 - g)) u_cell (
        .clk (clk), .en (adv),
        .rem_i (dv_rem[l][g]), .den_i (dv_den[l][g]), .q_i (dv_q[l][g]),
        .rem_o (dv_rem[l][g+1]), .den_o (dv_den[l][g+1]), .q_o (dv_q[l][g+1])
      );
    end
  end

  // ---------------- matrix assembly ----------------
  logic signed [31:0]   u_r [3];
  logic signed [XW-1:0] c1_r, s1_r, c2_r, c3_r;
  logic                 z1_r, z2_r, z3_r, z4_r;
  logic signed [63:0]   p_r [6];
  logic signed [XW+31:0] su_r [3];
  logic signed [XW+31:0] su3_r [3];
  logic signed [XW:0]   omc_r;
  logic signed [63:0]   pr [6];
  logic signed [33:0]   aat [6];
  logic signed [68:0]   t_r [6];
  logic signed [71:0]   acc [9];
  logic signed [71:0]   dual [9];
  logic signed [71:0]   diag [9];
  logic [15:0]          ent_r [9];
  logic [15:0]          ent [9];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pr[k]  = p_r[k] + RND29;
      aat[k] = pr[k][63:30];
    end
    for (int e = 0; e < 9; e++) begin
      case (e)
        1:       dual[e] =  72'(su3_r[2]);
        2:       dual[e] = -72'(su3_r[1]);
        3:       dual[e] = -72'(su3_r[2]);
        5:       dual[e] =  72'(su3_r[0]);
        6:       dual[e] =  72'(su3_r[1]);
        7:       dual[e] = -72'(su3_r[0]);
        default: dual[e] = '0;
      endcase
      diag[e] = (e == 0 || e == 4 || e == 8) ?
                $signed({{8{c3_r[XW-1]}}, c3_r, 30'b0}) : 72'sd0;
      acc[e] = $signed({{3{t_r[PIDX[e]][68]}}, t_r[PIDX[e]]}) + diag[e] + dual[e] + RND45;
      if (z3_r)
        ent[e] = (e == 0 || e == 4 || e == 8) ? acr_pkg::ACR_ONE_Q14 : 16'd0;
      else
        ent[e] = sat16(acc[e][71:46]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        u_r[l] <= sd_r[MIDX].neg[l] ? -$signed({1'b0, dv_q[l][DV]})
                                    :  $signed({1'b0, dv_q[l][DV]});
      end
      c1_r <= sd_r[MIDX].flip ? -xd_r[DLY] : xd_r[DLY];
      s1_r <= yd_r[DLY];
      z1_r <= sd_r[MIDX].zero;

      p_r[0] <= u_r[0] * u_r[0];
      p_r[1] <= u_r[1] * u_r[1];
      p_r[2] <= u_r[2] * u_r[2];
      p_r[3] <= u_r[0] * u_r[1];
      p_r[4] <= u_r[0] * u_r[2];
      p_r[5] <= u_r[1] * u_r[2];
      for (int l = 0; l < 3; l++) begin
        su_r[l] <= s1_r * u_r[l];
      end
      omc_r <= ONE35 - {c1_r[XW-1], c1_r};
      c2_r  <= c1_r;
      z2_r  <= z1_r;

      for (int k = 0; k < 6; k++) begin
        t_r[k] <= omc_r * aat[k];
      end
      su3_r <= su_r;
      c3_r  <= c2_r;
      z3_r  <= z2_r;

      ent_r <= ent;
      z4_r  <= z3_r;
    end
  end

  // ---------------- row buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      row_r <= 2'd0;
    end else if (load) begin
      ov_r  <= 1'b1;
      row_r <= 2'd0;
    end else if (out_acc) begin
      if (last)
        ov_r <= 1'b0;
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      eb_r <= ent_r;
      zb_r <= z4_r;
    end
  end

  logic [3:0] base;
  always_comb begin
    base = {1'b0, row_r, 1'b0} + {2'b0, row_r};
    if (last) begin
      out_col0 = '0;
      out_col1 = '0;
      out_col2 = '0;
      out_col3 = acr_pkg::ACR_ONE_Q14;
    end else begin
      out_col0 = eb_r[base];
      out_col1 = eb_r[base + 4'd1];
      out_col2 = eb_r[base + 4'd2];
      out_col3 = '0;
    end
  end

  assign out_valid     = ov_r;
  assign out_row_index = row_r;
  assign out_last_row  = last;
  assign out_axis_zero = zb_r;

  // ---------------- checks ----------------
  `ASSERT_NEXT(a_row_step, out_acc && !last, ov_r && row_r == $past(row_r) + 2'd1)
  `ASSERT_NEXT(a_load_first_row, load, ov_r && row_r == 2'd0)
  `ASSERT_SAME(a_hold_when_full, v_r[NST-1] && ov_r && !(out_acc && last), in_stall)

endmodule
`default_nettype wire

FILE: rtl/acr_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module acr_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [acr_pkg::ACR_XW-1:0] x_i,
  input  wire logic signed [acr_pkg::ACR_XW-1:0] y_i,
  input  wire logic signed [acr_pkg::ACR_ZW-1:0] z_i,
  output logic signed [acr_pkg::ACR_XW-1:0]      x_o,
  output logic signed [acr_pkg::ACR_XW-1:0]      y_o,
  output logic signed [acr_pkg::ACR_ZW-1:0]      z_o
);

  logic signed [acr_pkg::ACR_XW-1:0] dx, dy;
  logic signed [acr_pkg::ACR_ZW-1:0] at;

  always_comb begin
    dx = y_i >>> STEP;  // floor shift
    dy = x_i >>> STEP;
    at = $signed(acr_pkg::acr_atan(STEP));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[acr_pkg::ACR_ZW-1]) begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + at;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/acr_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module acr_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [acr_pkg::ACR_REMW-1:0]   rem_i,
  input  wire logic [acr_pkg::ACR_ROOTW-1:0]  root_i,
  output logic [acr_pkg::ACR_REMW-1:0]        rem_o,
  output logic [acr_pkg::ACR_ROOTW-1:0]       root_o
);

  localparam int PADW = acr_pkg::ACR_REMW - acr_pkg::ACR_ROOTW;

  logic [acr_pkg::ACR_REMW-1:0] trial;
  logic ge;

  // (2r + 2^b) * 2^b, r has no bits at or below b
  always_comb begin
    trial = ({{PADW{1'b0}}, root_i} << (BIT + 1))
          + ({{(acr_pkg::ACR_REMW-1){1'b0}}, 1'b1} << (2 * BIT));
    ge = rem_i >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? rem_i - trial : rem_i;
      root_o <= ge ? root_i | ({{(acr_pkg::ACR_ROOTW-1){1'b0}}, 1'b1} << BIT) : root_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/acr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module acr_div_cell #(
  parameter int BIT = 0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [acr_pkg::ACR_DVW-1:0]    rem_i,
  input  wire logic [acr_pkg::ACR_ROOTW-1:0]  den_i,
  input  wire logic [acr_pkg::ACR_ROOTW-1:0]  q_i,
  output logic [acr_pkg::ACR_DVW-1:0]         rem_o,
  output logic [acr_pkg::ACR_ROOTW-1:0]       den_o,
  output logic [acr_pkg::ACR_ROOTW-1:0]       q_o
);

  localparam int PADW = acr_pkg::ACR_DVW - acr_pkg::ACR_ROOTW;

  logic [acr_pkg::ACR_DVW-1:0] sub;
  logic ge;

  always_comb begin
    sub = {{PADW{1'b0}}, den_i} << BIT;
    ge  = rem_i >= sub;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? rem_i - sub : rem_i;
      den_o <= den_i;
      q_o   <= ge ? q_i | ({{(acr_pkg::ACR_ROOTW-1){1'b0}}, 1'b1} << BIT) : q_i;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic signed [15:0] ang;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } rot_req_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [15:0] c0;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
    logic signed [15:0] c3;
    logic               last;
    logic               zero;
  } mat_row_t;

  localparam int        STEPS   = 16;
  localparam longint    ONE_Q30 = 64'sd1073741824;
  localparam longint    GAIN    = 64'sd652032875;
  localparam longint    D2R     = 64'sd292818;
  localparam int        TURN    = 23040;
  localparam int        HALF    = 11520;
  localparam int        QUARTER = 5760;

  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
    1024, 512, 256, 128};

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] in_angle_deg = '0, in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_row_index;
  logic signed [15:0] out_col0, out_col1, out_col2, out_col3;
  logic out_last_row, out_axis_zero;

  axis_angle_rotation_matrix_top u_top (.*);

  rot_req_t pending_reqs[$];
  mat_row_t expected_rows[$];
  int       n_errors = 0;
  int       n_rows = 0;
  int       n_reqs = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       stim_done = 0;

  initial forever #4 clk = ~clk;

  function automatic longint sar(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint unit_comp(longint a, longint len);
    longint m, q;
    m = (a < 0 ? -a : a) << 45;
    q = (m + (len >>> 1)) / len;
    return a < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // build the 4 row items for one request
  task automatic predict_matrix(rot_req_t q);
    longint m_ang, x, y, zr, dx, dy, c, s, l2, len, aat, dual, acc;
    longint u[3];
    longint ax[3];
    longint mat[4][4];
    bit flip, zero;
    mat_row_t r;
    ax[0] = q.ax;
    ax[1] = q.ay;
    ax[2] = q.az;
    zero = (q.ax == 0 && q.ay == 0 && q.az == 0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) mat[i][j] = (i == j) ? 16384 : 0;
    if (!zero) begin
      m_ang = longint'(q.ang) % TURN;
      flip = 0;
      if (m_ang < 0) m_ang += TURN;
      if (m_ang >= HALF) m_ang -= TURN;
      if (m_ang > QUARTER) begin
        m_ang = HALF - m_ang;
        flip = 1;
      end else if (m_ang < -QUARTER) begin
        m_ang = -HALF - m_ang;
        flip = 1;
      end
      zr = m_ang * D2R;
      x = GAIN;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = sar(y, i);
        dy = sar(x, i);
        if (zr >= 0) begin
          x -= dx; y += dy; zr -= ATAN_Q30[i];
        end else begin
          x += dx; y -= dy; zr += ATAN_Q30[i];
        end
      end
      c = flip ? -x : x;
      s = y;
      l2 = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
      len = root64(longint'(l2) << 30);
      for (int i = 0; i < 3; i++) u[i] = unit_comp(ax[i], len);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          aat = sar(u[i] * u[j] + (ONE_Q30 >>> 1), 30);
          acc = (ONE_Q30 - c) * aat;
          if (i == j) acc += c * ONE_Q30;
          dual = 0;
          if (i == 0 && j == 1) dual = u[2];
          if (i == 0 && j == 2) dual = -u[1];
          if (i == 1 && j == 0) dual = -u[2];
          if (i == 1 && j == 2) dual = u[0];
          if (i == 2 && j == 0) dual = u[1];
          if (i == 2 && j == 1) dual = -u[0];
          acc += s * dual;
          mat[i][j] = sar(acc + (64'sd1 <<< 45), 46);
        end
    end
    for (int i = 0; i < 4; i++) begin
      r.row = i[1:0];
      r.c0 = clip16(mat[i][0]);
      r.c1 = clip16(mat[i][1]);
      r.c2 = clip16(mat[i][2]);
      r.c3 = clip16(mat[i][3]);
      r.last = (i == 3);
      r.zero = zero;
      expected_rows.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch %s at row item %0d: got %0d, want %0d", what, n_rows, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n_reqs++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          rot_req_t q;
          q = pending_reqs.pop_front();
          predict_matrix(q);
          in_valid     <= 1'b1;
          in_angle_deg <= q.ang;
          in_axis_x    <= q.ax;
          in_axis_y    <= q.ay;
          in_axis_z    <= q.az;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected item", out_row_index, -1);
      end else begin
        mat_row_t e;
        e = expected_rows.pop_front();
        if (out_row_index !== e.row) report_mismatch("row_index", out_row_index, e.row);
        if (out_col0 !== e.c0) report_mismatch("col0", out_col0, e.c0);
        if (out_col1 !== e.c1) report_mismatch("col1", out_col1, e.c1);
        if (out_col2 !== e.c2) report_mismatch("col2", out_col2, e.c2);
        if (out_col3 !== e.c3) report_mismatch("col3", out_col3, e.c3);
        if (out_last_row !== e.last) report_mismatch("last_row", out_last_row, e.last);
        if (out_axis_zero !== e.zero) report_mismatch("axis_zero", out_axis_zero, e.zero);
      end
      n_rows++;
    end
  end

  function automatic rot_req_t mk(int a, int x, int y, int z);
    rot_req_t q;
    q.ang = a[15:0];
    q.ax = x[15:0];
    q.ay = y[15:0];
    q.az = z[15:0];
    return q;
  endfunction

  function automatic logic [15:0] rnd_field();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(0, 64) - 32);
      2: return 16'($urandom_range(1) ? 16'h7fff - $urandom_range(3)
                                      : 16'h8000 + $urandom_range(3));
      default: return 16'($urandom_range(2000) - 1000);
    endcase
  endfunction

  function automatic rot_req_t rnd_req();
    rot_req_t q;
    q.ang = 16'($urandom_range(65535));
    q.ax = rnd_field();
    q.ay = rnd_field();
    q.az = rnd_field();
    if ($urandom_range(19) == 0) begin
      q.ax = '0; q.ay = '0; q.az = '0;
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rows.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int pct_idle[4] = '{0, 67, 0, 29};
    int pct_stall[4] = '{0, 0, 67, 29};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: zero axis, extreme angles, wrap, quarter/half turns, long axes
    pending_reqs.push_back(mk(0, 0, 0, 0));
    pending_reqs.push_back(mk(32767, 0, 0, 0));
    pending_reqs.push_back(mk(0, 1, 0, 0));
    pending_reqs.push_back(mk(5760, 0, 0, 1));
    pending_reqs.push_back(mk(-5760, 0, 1, 0));
    pending_reqs.push_back(mk(11520, 1, 1, 1));
    pending_reqs.push_back(mk(-11520, -1, -1, -1));
    pending_reqs.push_back(mk(5761, 3, -4, 5));
    pending_reqs.push_back(mk(-5761, 7, 0, -2));
    pending_reqs.push_back(mk(23040, 0, 5, 0));
    pending_reqs.push_back(mk(23040 + 1920, 1, 2, 3));
    pending_reqs.push_back(mk(32767, 32767, 32767, 32767));
    pending_reqs.push_back(mk(-32768, -32768, -32768, -32768));
    pending_reqs.push_back(mk(2880, -32768, 0, 0));
    pending_reqs.push_back(mk(-2880, 0, 0, 32767));
    pending_reqs.push_back(mk(11519, 32767, -32768, 1));
    pending_reqs.push_back(mk(-11521, 1, -1, 32767));
    pending_reqs.push_back(mk(1, 100, 200, -300));
    pending_reqs.push_back(mk(-1, -5, 5, 0));
    pending_reqs.push_back(mk(-32768, 0, 0, 0));
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pct_idle[ph];
      stall_pct = pct_stall[ph];
      for (int i = 0; i < 78; i++) pending_reqs.push_back(rnd_req());
      wait_drained();
    end
    stim_done = 1;
    idle_pct = 0;
    stall_pct = 0;
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d row items over four idle/stall mixes",
             n_reqs, n_rows);
    if (n_errors == 0 && expected_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d rows never came", n_errors, expected_rows.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("TB_ERROR");
    $finish;
  end

endmodule
